// File: rtl/core/tdct_pkg.sv
`timescale 1ns / 1ps
// Shared types, constants and the color table of the tilt cursor tracker.
package tdct_pkg;

   // Field widths fixed by the channel and register definitions.
   localparam int RAW_W   = 13;
   localparam int SCALE_W = 6;
   localparam int SIZE_W  = 10;
   localparam int COORD_W = 10;
   localparam int COLOR_W = 16;
   localparam int CIDX_W  = 3;
   localparam int FILT_W  = 24;

   // Configuration port.
   localparam int CSR_IDX_W  = 2;
   localparam int CSR_DATA_W = 10;
   localparam logic [CSR_IDX_W-1:0] CSR_SCREEN_WIDTH  = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_SCREEN_HEIGHT = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_SENSOR_SCALE  = 2'd2;

   // Register reset values.
   localparam int SCREEN_W_RST = 320;
   localparam int SCREEN_H_RST = 240;
   localparam logic [SCALE_W-1:0] SCALE_RST = 6'd4;

   // Defaults for the top level parameters.
   localparam int BOX_HALF_DEF  = 2;
   localparam int FRAC_BITS_DEF = 8;

   // Division by 100 through a reciprocal. The product is exact for every
   // dividend below 2^23, which covers both quotient steps.
   localparam int MAG_W       = 18;
   localparam int Q1_W        = 12;
   localparam int REM_W       = 7;
   localparam int RECIP_SHIFT = 30;
   localparam logic [23:0] RECIP       = 24'd10737419;
   localparam logic [REM_W-1:0] DIVISOR = 7'd100;

   // Low-pass filter coefficients over 256.
   localparam logic [7:0] COEF_KEEP = 8'd205;
   localparam logic [7:0] COEF_NEW  = 8'd51;
   localparam int FILT_SHIFT = 8;

   localparam logic [CIDX_W-1:0] COLOR_LAST = 3'd6;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_MAG,
      ST_RCP1,
      ST_QUO1,
      ST_REM,
      ST_RCP2,
      ST_GVAL,
      ST_KEEP,
      ST_FILT,
      ST_MOVE,
      ST_OUT
   } state_type;

   function automatic logic [COLOR_W-1:0] palette(input logic [CIDX_W-1:0] idx);
      logic [COLOR_W-1:0] c;
      case (idx)
         3'd0:    c = 16'hFFFF;
         3'd1:    c = 16'hF800;
         3'd2:    c = 16'h07E0;
         3'd3:    c = 16'hFFE0;
         3'd4:    c = 16'h001F;
         3'd5:    c = 16'hF81F;
         3'd6:    c = 16'h07FF;
         default: c = 16'hFFFF;
      endcase
      return c;
   endfunction

endpackage

// File: rtl/core/tdct_if.sv
`timescale 1ns / 1ps
// Valid/ready channel interfaces for readings in and box results out.
interface tdct_req_if;
   logic                                 valid;
   logic                                 ready;
   logic                                 data_ready;
   logic                                 double_tap;
   logic                                 single_tap;
   logic signed [tdct_pkg::RAW_W-1:0]    accel_x;
   logic signed [tdct_pkg::RAW_W-1:0]    accel_y;

   modport source (output valid, data_ready, double_tap, single_tap, accel_x, accel_y,
                   input ready);
   modport sink   (input valid, data_ready, double_tap, single_tap, accel_x, accel_y,
                   output ready);
endinterface

interface tdct_rsp_if;
   logic                            valid;
   logic                            ready;
   logic [tdct_pkg::COORD_W-1:0]    box_left;
   logic [tdct_pkg::COORD_W-1:0]    box_top;
   logic [tdct_pkg::COORD_W-1:0]    box_right;
   logic [tdct_pkg::COORD_W-1:0]    box_bottom;
   logic [tdct_pkg::COLOR_W-1:0]    box_color;

   modport source (output valid, box_left, box_top, box_right, box_bottom, box_color,
                   input ready);
   modport sink   (input valid, box_left, box_top, box_right, box_bottom, box_color,
                   output ready);
endinterface

// File: rtl/core/tilt_driven_cursor_tracker_unit.sv
`timescale 1ns / 1ps
// Top level of the tilt cursor tracker: sequencer, state and result register.
//
// The block takes one accelerometer reading per transfer on req_if (X and Y
// samples plus the data-ready and tap flags) and returns one transfer on
// rsp_if with the four box corners and the RGB565 color of the cursor.
// Screen width, screen height and sensor scale are written through the csr_
// port; the user must write them only while the block is idle, which the block
// itself does not enforce. They take effect for the next reading.
// Every multiply runs through a single shared multiplier under a small
// sequencer, nine steps per axis: scale the sample, two reciprocal divides
// by 100 with a remainder step, the two filter products, the filter sum with
// saturation, and the cursor add with clamping. Both axes pass through these
// steps, and a final output step then registers the result. req_if.ready is
// high only while the sequencer is idle, so the block takes no new reading
// until it has returned to idle.
//
// The result sits in an output register. If the receiver stalls, the block
// still accepts and processes the next reading and then waits in its last
// step until the held result has been taken.
//
// Reset is synchronous and active high. It restores the register defaults
// (320 x 240 screen, scale 4), clears the filters and the color index, and
// centers the cursor on the default screen.
module tilt_driven_cursor_tracker_unit #(
   parameter int BOX_HALF  = tdct_pkg::BOX_HALF_DEF,
   parameter int FRAC_BITS = tdct_pkg::FRAC_BITS_DEF
) (
   input  logic                                 clock,
   input  logic                                 reset,
   tdct_req_if.sink                             req_if,
   tdct_rsp_if.source                           rsp_if,
   input  logic                                 csr_we,
   input  logic [tdct_pkg::CSR_IDX_W-1:0]       csr_index,
   input  logic [tdct_pkg::CSR_DATA_W-1:0]      csr_wdata
);

   // Magnitude of a scaled sample, and the same with a sign bit.
   localparam int GABS_W = tdct_pkg::Q1_W + FRAC_BITS;
   localparam int G_W    = GABS_W + 1;
   // Multiplier operands must hold the 24-bit reciprocal and a filter input.
   localparam int OP_W   = (G_W > 25) ? G_W : 25;
   localparam int PROD_W = 2 * OP_W;
   // Cursor in fixed point, signed so that a tiny screen can clamp below zero.
   localparam int CUR_W  = FRAC_BITS + 11;
   localparam int ADD_W  = ((CUR_W > tdct_pkg::FILT_W) ? CUR_W : tdct_pkg::FILT_W) + 1;

   localparam logic signed [ADD_W-1:0] BOX_EXT = ADD_W'(BOX_HALF);
   localparam logic signed [ADD_W-1:0] LO_FIX  = ADD_W'(BOX_HALF) <<< FRAC_BITS;
   localparam logic [tdct_pkg::COORD_W-1:0] BOX_COORD = tdct_pkg::COORD_W'(BOX_HALF);
   localparam logic signed [CUR_W-1:0] CUR_X_RST =
      CUR_W'(tdct_pkg::SCREEN_W_RST / 2) << FRAC_BITS;
   localparam logic signed [CUR_W-1:0] CUR_Y_RST =
      CUR_W'(tdct_pkg::SCREEN_H_RST / 2) << FRAC_BITS;

   tdct_pkg::state_type state_ff, state_in;
   logic axis_ff, axis_in;

   logic [tdct_pkg::SIZE_W-1:0]  screen_w_ff;
   logic [tdct_pkg::SIZE_W-1:0]  screen_h_ff;
   logic [tdct_pkg::SCALE_W-1:0] scale_ff;

   logic signed [tdct_pkg::RAW_W-1:0] raw_x_ff, raw_x_in;
   logic signed [tdct_pkg::RAW_W-1:0] raw_y_ff, raw_y_in;
   logic [tdct_pkg::CIDX_W-1:0]       color_ff, color_in, color_next;
   logic [tdct_pkg::MAG_W-1:0]        mag_ff, mag_in;
   logic [tdct_pkg::Q1_W-1:0]         q1_ff, q1_in;
   logic [tdct_pkg::REM_W-1:0]        rem_ff, rem_in;
   logic signed [G_W-1:0]             g_ff, g_in;
   logic signed [PROD_W-1:0]          keep_ff, keep_in;
   logic signed [tdct_pkg::FILT_W-1:0] filt_x_ff, filt_x_in;
   logic signed [tdct_pkg::FILT_W-1:0] filt_y_ff, filt_y_in;
   logic signed [CUR_W-1:0]           cur_x_ff, cur_x_in;
   logic signed [CUR_W-1:0]           cur_y_ff, cur_y_in;

   logic                              rsp_valid_ff, rsp_valid_in;
   logic [tdct_pkg::COORD_W-1:0]      box_left_ff, box_left_in;
   logic [tdct_pkg::COORD_W-1:0]      box_top_ff, box_top_in;
   logic [tdct_pkg::COORD_W-1:0]      box_right_ff, box_right_in;
   logic [tdct_pkg::COORD_W-1:0]      box_bottom_ff, box_bottom_in;
   logic [tdct_pkg::COLOR_W-1:0]      box_color_ff, box_color_in;

   // Shared multiplier.
   logic                     mul_en;
   logic signed [OP_W-1:0]   mul_a;
   logic signed [OP_W-1:0]   mul_b;
   logic signed [PROD_W-1:0] mul_prod;

   // Values of the axis being worked on.
   logic signed [tdct_pkg::RAW_W-1:0]  raw_sel;
   logic [tdct_pkg::RAW_W-1:0]         abs_raw;
   logic                               neg_sel;
   logic signed [tdct_pkg::FILT_W-1:0] filt_sel;
   logic signed [CUR_W-1:0]            cur_sel;
   logic [tdct_pkg::SIZE_W-1:0]        size_sel;

   logic [FRAC_BITS-1:0]               q2;
   logic [GABS_W-1:0]                  gabs;
   logic signed [PROD_W-1:0]           filt_sum;
   logic signed [PROD_W-1:0]           filt_shr;
   logic                               filt_fits;
   logic signed [tdct_pkg::FILT_W-1:0] filt_new;
   logic signed [ADD_W-1:0]            pos;
   logic signed [ADD_W-1:0]            size_ext;
   logic signed [ADD_W-1:0]            hi_fix;
   logic signed [CUR_W-1:0]            cur_new;
   logic                               out_free;

   tdct_mul #(
      .OP_W (OP_W)
   ) u_mul (
      .clock (clock),
      .en    (mul_en),
      .a     (mul_a),
      .b     (mul_b),
      .prod  (mul_prod)
   );

   // Per-axis selection. The Y sample is negated, so its result is negative
   // exactly when the raw Y sample is positive.
   always_comb begin
      raw_sel  = axis_ff ? raw_y_ff : raw_x_ff;
      abs_raw  = raw_sel[tdct_pkg::RAW_W-1] ? tdct_pkg::RAW_W'(-raw_sel)
                                             : tdct_pkg::RAW_W'(raw_sel);
      neg_sel  = axis_ff ? (!raw_y_ff[tdct_pkg::RAW_W-1] && (raw_y_ff != '0))
                         : raw_x_ff[tdct_pkg::RAW_W-1];
      filt_sel = axis_ff ? filt_y_ff : filt_x_ff;
      cur_sel  = axis_ff ? cur_y_ff : cur_x_ff;
      size_sel = axis_ff ? screen_h_ff : screen_w_ff;
   end

   // Color index step. A double tap wins over a single tap, and neither
   // counts unless the reading says its tap flags are valid.
   always_comb begin
      color_next = color_ff;
      if (req_if.data_ready) begin
         if (req_if.double_tap) begin
            color_next = (color_ff >= tdct_pkg::COLOR_LAST) ? '0 : color_ff + 3'd1;
         end else if (req_if.single_tap) begin
            color_next = ((color_ff == '0) || (color_ff > tdct_pkg::COLOR_LAST))
                         ? tdct_pkg::COLOR_LAST : color_ff - 3'd1;
         end
      end
   end

   // Datapath pieces that feed register updates.
   always_comb begin
      // The low quotient digits of |sample * scale * 2^FRAC_BITS| / 100 come
      // from the remainder of the first divide, so the magnitude is a plain
      // concatenation of both quotients.
      q2   = mul_prod[tdct_pkg::RECIP_SHIFT +: FRAC_BITS];
      gabs = {q1_ff, q2};

      // Filter: (205 a + 51 g) / 256 rounded down, saturated to 24 bits.
      filt_sum  = keep_ff + mul_prod;
      filt_shr  = filt_sum >>> tdct_pkg::FILT_SHIFT;
      filt_fits = (filt_shr[PROD_W-1:tdct_pkg::FILT_W-1] == '0) ||
                  (filt_shr[PROD_W-1:tdct_pkg::FILT_W-1] == '1);
      if (filt_fits) begin
         filt_new = filt_shr[tdct_pkg::FILT_W-1:0];
      end else if (filt_shr[PROD_W-1]) begin
         filt_new = {1'b1, {(tdct_pkg::FILT_W-1){1'b0}}};
      end else begin
         filt_new = {1'b0, {(tdct_pkg::FILT_W-1){1'b1}}};
      end

      // Cursor: the lower bound is tested first, so on a screen narrower than the box
      // a position below the lower bound lands on it, and any other on the upper bound.
      pos      = ADD_W'(cur_sel) + ADD_W'(filt_sel);
      size_ext = ADD_W'(size_sel);
      hi_fix   = (size_ext - BOX_EXT) <<< FRAC_BITS;
      if (pos < LO_FIX) begin
         cur_new = CUR_W'(LO_FIX);
      end else if (pos > hi_fix) begin
         cur_new = CUR_W'(hi_fix);
      end else begin
         cur_new = CUR_W'(pos);
      end

      out_free = !rsp_valid_ff || rsp_if.ready;
   end

   // Sequencer: next state, multiplier operands and register updates.
   always_comb begin
      state_in      = state_ff;
      axis_in       = axis_ff;
      raw_x_in      = raw_x_ff;
      raw_y_in      = raw_y_ff;
      color_in      = color_ff;
      mag_in        = mag_ff;
      q1_in         = q1_ff;
      rem_in        = rem_ff;
      g_in          = g_ff;
      keep_in       = keep_ff;
      filt_x_in     = filt_x_ff;
      filt_y_in     = filt_y_ff;
      cur_x_in      = cur_x_ff;
      cur_y_in      = cur_y_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_if.ready;
      box_left_in   = box_left_ff;
      box_top_in    = box_top_ff;
      box_right_in  = box_right_ff;
      box_bottom_in = box_bottom_ff;
      box_color_in  = box_color_ff;
      mul_en        = 1'b0;
      mul_a         = '0;
      mul_b         = '0;

      case (state_ff)
         tdct_pkg::ST_IDLE: begin
            if (req_if.valid) begin
               raw_x_in = req_if.accel_x;
               raw_y_in = req_if.accel_y;
               color_in = color_next;
               axis_in  = 1'b0;
               state_in = tdct_pkg::ST_MAG;
            end
         end
         tdct_pkg::ST_MAG: begin
            mul_en   = 1'b1;
            mul_a    = OP_W'(abs_raw);
            mul_b    = OP_W'(scale_ff);
            state_in = tdct_pkg::ST_RCP1;
         end
         tdct_pkg::ST_RCP1: begin
            mag_in   = mul_prod[tdct_pkg::MAG_W-1:0];
            mul_en   = 1'b1;
            mul_a    = OP_W'(mul_prod[tdct_pkg::MAG_W-1:0]);
            mul_b    = OP_W'(tdct_pkg::RECIP);
            state_in = tdct_pkg::ST_QUO1;
         end
         tdct_pkg::ST_QUO1: begin
            q1_in    = mul_prod[tdct_pkg::RECIP_SHIFT +: tdct_pkg::Q1_W];
            mul_en   = 1'b1;
            mul_a    = OP_W'(mul_prod[tdct_pkg::RECIP_SHIFT +: tdct_pkg::Q1_W]);
            mul_b    = OP_W'(tdct_pkg::DIVISOR);
            state_in = tdct_pkg::ST_REM;
         end
         tdct_pkg::ST_REM: begin
            rem_in   = tdct_pkg::REM_W'(mag_ff - mul_prod[tdct_pkg::MAG_W-1:0]);
            state_in = tdct_pkg::ST_RCP2;
         end
         tdct_pkg::ST_RCP2: begin
            mul_en   = 1'b1;
            mul_a    = OP_W'({rem_ff, {FRAC_BITS{1'b0}}});
            mul_b    = OP_W'(tdct_pkg::RECIP);
            state_in = tdct_pkg::ST_GVAL;
         end
         tdct_pkg::ST_GVAL: begin
            g_in     = neg_sel ? -$signed({1'b0, gabs}) : $signed({1'b0, gabs});
            mul_en   = 1'b1;
            mul_a    = OP_W'(filt_sel);
            mul_b    = OP_W'(tdct_pkg::COEF_KEEP);
            state_in = tdct_pkg::ST_KEEP;
         end
         tdct_pkg::ST_KEEP: begin
            keep_in  = mul_prod;
            mul_en   = 1'b1;
            mul_a    = OP_W'(g_ff);
            mul_b    = OP_W'(tdct_pkg::COEF_NEW);
            state_in = tdct_pkg::ST_FILT;
         end
         tdct_pkg::ST_FILT: begin
            if (axis_ff) begin
               filt_y_in = filt_new;
            end else begin
               filt_x_in = filt_new;
            end
            state_in = tdct_pkg::ST_MOVE;
         end
         tdct_pkg::ST_MOVE: begin
            if (axis_ff) begin
               cur_y_in = cur_new;
               state_in = tdct_pkg::ST_OUT;
            end else begin
               cur_x_in = cur_new;
               axis_in  = 1'b1;
               state_in = tdct_pkg::ST_MAG;
            end
         end
         tdct_pkg::ST_OUT: begin
            if (out_free) begin
               box_left_in   = cur_x_ff[FRAC_BITS +: tdct_pkg::COORD_W] - BOX_COORD;
               box_top_in    = cur_y_ff[FRAC_BITS +: tdct_pkg::COORD_W] - BOX_COORD;
               box_right_in  = cur_x_ff[FRAC_BITS +: tdct_pkg::COORD_W] + BOX_COORD;
               box_bottom_in = cur_y_ff[FRAC_BITS +: tdct_pkg::COORD_W] + BOX_COORD;
               box_color_in  = tdct_pkg::palette(color_ff);
               rsp_valid_in  = 1'b1;
               axis_in       = 1'b0;
               state_in      = tdct_pkg::ST_IDLE;
            end
         end
         default: begin
            axis_in  = 1'b0;
            state_in = tdct_pkg::ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= tdct_pkg::ST_IDLE;
         axis_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
         color_ff     <= '0;
         filt_x_ff    <= '0;
         filt_y_ff    <= '0;
         cur_x_ff     <= CUR_X_RST;
         cur_y_ff     <= CUR_Y_RST;
      end else begin
         state_ff     <= state_in;
         axis_ff      <= axis_in;
         rsp_valid_ff <= rsp_valid_in;
         color_ff     <= color_in;
         filt_x_ff    <= filt_x_in;
         filt_y_ff    <= filt_y_in;
         cur_x_ff     <= cur_x_in;
         cur_y_ff     <= cur_y_in;
      end
   end

   always_ff @(posedge clock) begin
      raw_x_ff      <= raw_x_in;
      raw_y_ff      <= raw_y_in;
      mag_ff        <= mag_in;
      q1_ff         <= q1_in;
      rem_ff        <= rem_in;
      g_ff          <= g_in;
      keep_ff       <= keep_in;
      box_left_ff   <= box_left_in;
      box_top_ff    <= box_top_in;
      box_right_ff  <= box_right_in;
      box_bottom_ff <= box_bottom_in;
      box_color_ff  <= box_color_in;
   end

   // Configuration registers; writes to an index past the list are dropped.
   always_ff @(posedge clock) begin
      if (reset) begin
         screen_w_ff <= tdct_pkg::SIZE_W'(tdct_pkg::SCREEN_W_RST);
         screen_h_ff <= tdct_pkg::SIZE_W'(tdct_pkg::SCREEN_H_RST);
         scale_ff    <= tdct_pkg::SCALE_RST;
      end else if (csr_we) begin
         case (csr_index)
            tdct_pkg::CSR_SCREEN_WIDTH:  screen_w_ff <= csr_wdata;
            tdct_pkg::CSR_SCREEN_HEIGHT: screen_h_ff <= csr_wdata;
            tdct_pkg::CSR_SENSOR_SCALE:  scale_ff    <= csr_wdata[tdct_pkg::SCALE_W-1:0];
            default: begin
            end
         endcase
      end
   end

   assign req_if.ready      = (state_ff == tdct_pkg::ST_IDLE);
   assign rsp_if.valid      = rsp_valid_ff;
   assign rsp_if.box_left   = box_left_ff;
   assign rsp_if.box_top    = box_top_ff;
   assign rsp_if.box_right  = box_right_ff;
   assign rsp_if.box_bottom = box_bottom_ff;
   assign rsp_if.box_color  = box_color_ff;

   // The reciprocal divide must leave a remainder below the divisor.
   a_rem_range: assert property (@(posedge clock) disable iff (reset)
      (state_ff == tdct_pkg::ST_REM) |=> (rem_ff < tdct_pkg::DIVISOR))
      else $error("remainder of the first divide is not below the divisor");

   // The second quotient must fit in the fraction bits it is packed into.
   a_q2_fits: assert property (@(posedge clock) disable iff (reset)
      (state_ff == tdct_pkg::ST_GVAL) |->
      (mul_prod[PROD_W-1:tdct_pkg::RECIP_SHIFT+FRAC_BITS] == '0))
      else $error("second quotient overflows the fraction bits");

   a_color_range: assert property (@(posedge clock) disable iff (reset)
      color_ff <= tdct_pkg::COLOR_LAST)
      else $error("color index left the palette range");

   a_idle_axis: assert property (@(posedge clock) disable iff (reset)
      (state_ff == tdct_pkg::ST_IDLE) |-> !axis_ff)
      else $error("axis select not cleared when idle");

   a_result_load: assert property (@(posedge clock) disable iff (reset)
      (state_ff == tdct_pkg::ST_OUT && out_free) |=>
      (rsp_valid_ff && state_ff == tdct_pkg::ST_IDLE))
      else $error("finished result not presented on the response channel");

endmodule

// File: rtl/core/tdct_mul.sv
`timescale 1ns / 1ps
// Shared signed multiplier with a registered product.
module tdct_mul #(
   parameter int OP_W = 25
) (
   input  logic                       clock,
   input  logic                       en,
   input  logic signed [OP_W-1:0]     a,
   input  logic signed [OP_W-1:0]     b,
   output logic signed [2*OP_W-1:0]   prod
);

   logic signed [2*OP_W-1:0] prod_in;
   logic signed [2*OP_W-1:0] prod_ff;

   assign prod_in = a * b;

   always_ff @(posedge clock) begin
      if (en) begin
         prod_ff <= prod_in;
      end
   end

   assign prod = prod_ff;

endmodule
